### design/olid_pkg.sv
// Shared types and constants for the ordered list block.
`default_nettype none
package olid_pkg;

    localparam int OLID_DEPTH = 16;
    localparam int IN_BYTES_W = 40;
    localparam int OUT_BYTES_W = 40;

    typedef enum logic [2:0] {
        MODE_APPEND   = 3'd0,
        MODE_DEL_HEAD = 3'd1,
        MODE_DEL_TAIL = 3'd2,
        MODE_DEL_VAL  = 3'd3,
        MODE_DISPLAY  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_SHIFT,
        CELL_COMPARE,
        CELL_REMOVE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [31:0] din;
    } t_cell_ctl;

endpackage
`default_nettype wire

### design/olid_cell.sv
// One list cell: holds an entry, takes data from its neighbor or the input.
`default_nettype none
module olid_cell
    import olid_pkg::*;
#(
    parameter int LIST_DEPTH = OLID_DEPTH,
    parameter int IDX        = 0,
    localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
    input  wire              i_clk,
    input  t_cell_ctl        i_ctl,
    input  wire  [CW-1:0]    i_count,
    input  wire  [31:0]      i_next,
    input  wire  [31:0]      i_head,
    input  wire              i_rm_sel,
    output logic [31:0]      o_value,
    output logic             o_match
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [31:0] r_value, n_value;
    logic        r_match, n_match;

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        case (i_ctl.op)
            CELL_APPEND: begin
                if (IDX_C == i_count) begin
                    n_value = i_ctl.din;
                end
            end
            CELL_SHIFT: n_value = i_next;
            CELL_COMPARE: n_match = (r_value == i_ctl.din) && (IDX_C < i_count);
            CELL_REMOVE: begin
                if (i_rm_sel) begin
                    n_value = i_next;
                end
            end
            // circular step: tail slot wraps around to the head value
            CELL_ROTATE: n_value = (IDX_C == i_count - CW'(1)) ? i_head : i_next;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule
`default_nettype wire

### design/ordered_list_insert_delete.sv
// Bounded ordered list of signed 32-bit values built as a chain of cells.
// Input channel (s side): one item = mode + item_value. Output channel (m side):
// status and entry_value in tdata, last_result on tlast.
// Append, delete-first and delete-last: the result sits in the output register
// the cycle after the item is accepted. Delete-value: first every cell compares
// its entry, then, once the output register is free, the cells at and behind
// the first match take their neighbor's entry.
// Display: after the item is accepted, the chain rotates one step per emitted
// entry and so ends back in its original order.
// Undefined modes (5 to 7) are taken and dropped with no result.
// Throughput is one item per cycle for append, delete-first and delete-last,
// bounded by the one-deep output register.
// A stalled receiver freezes the block: the output register holds its item and
// no new input is taken and no display step advances until it drains.
// Reset (synchronous, active low) empties the list and drops any waiting
// result; cell contents are not reset.
`default_nettype none
module ordered_list_insert_delete
    import olid_pkg::*;
#(
    parameter int LIST_DEPTH = OLID_DEPTH,
    localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [IN_BYTES_W-1:0]  i_s_tdata,   // [2:0] mode, [34:3] item_value
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_BYTES_W-1:0] o_m_tdata,   // [1:0] status, [33:2] entry_value
    output logic                   o_m_tlast    // last_result
);

    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_DELV, S_DISP} t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_left, n_left;
    logic            r_ovalid, n_ovalid;
    t_status         r_ostatus, n_ostatus;
    logic [31:0]     r_oentry, n_oentry;
    logic            r_olast, n_olast;

    t_cell_ctl              cell_ctl;
    logic [31:0]            cell_val [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]  match_vec;
    logic [LIST_DEPTH-1:0]  rm_mask;
    logic                   out_free;
    logic                   in_acc;
    t_mode                  in_mode;
    logic [31:0]            in_value;

    assign in_mode  = t_mode'(i_s_tdata[2:0]);
    assign in_value = i_s_tdata[34:3];
    assign out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign in_acc = i_s_tvalid && o_s_tready;

    // first match and every cell behind it: m | -m
    assign rm_mask = match_vec | (~match_vec + LIST_DEPTH'(1));

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            logic [31:0] nxt;
            if (gi == LIST_DEPTH - 1) begin : g_end
                assign nxt = cell_val[gi];
            end else begin : g_mid
                assign nxt = cell_val[gi+1];
            end
            olid_cell #(
                .LIST_DEPTH (LIST_DEPTH),
                .IDX        (gi)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (cell_ctl),
                .i_count  (r_count),
                .i_next   (nxt),
                .i_head   (cell_val[0]),
                .i_rm_sel (rm_mask[gi]),
                .o_value  (cell_val[gi]),
                .o_match  (match_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_ostatus  = r_ostatus;
        n_oentry   = r_oentry;
        n_olast    = r_olast;
        cell_ctl.op  = CELL_HOLD;
        cell_ctl.din = in_value;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_oentry = '0;
                    n_olast  = 1'b1;
                    case (in_mode)
                        MODE_APPEND: begin
                            n_ovalid = 1'b1;
                            if (r_count == DEPTH_C) begin
                                n_ostatus = ST_FULL;
                            end else begin
                                n_ostatus   = ST_OK;
                                cell_ctl.op = CELL_APPEND;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        MODE_DEL_HEAD, MODE_DEL_TAIL: begin
                            n_ovalid = 1'b1;
                            if (r_count == '0) begin
                                n_ostatus = ST_EMPTY;
                            end else begin
                                n_ostatus = ST_OK;
                                n_count   = r_count - CW'(1);
                                if (in_mode == MODE_DEL_HEAD) begin
                                    cell_ctl.op = CELL_SHIFT;
                                end
                            end
                        end
                        MODE_DEL_VAL: begin
                            if (r_count == '0) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_EMPTY;
                            end else begin
                                cell_ctl.op = CELL_COMPARE;
                                n_state     = S_DELV;
                            end
                        end
                        MODE_DISPLAY: begin
                            if (r_count == '0) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_EMPTY;
                            end else begin
                                n_left  = r_count;
                                n_state = S_DISP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DELV: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oentry = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                    if (|match_vec) begin
                        n_ostatus   = ST_OK;
                        cell_ctl.op = CELL_REMOVE;
                        n_count     = r_count - CW'(1);
                    end else begin
                        n_ostatus = ST_NOT_FOUND;
                    end
                end
            end
            S_DISP: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_ostatus   = ST_OK;
                    n_oentry    = cell_val[0];
                    n_olast     = (r_left == CW'(1));
                    cell_ctl.op = CELL_ROTATE;
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
        r_ostatus <= n_ostatus;
        r_oentry  <= n_oentry;
        r_olast   <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {(OUT_BYTES_W - 34)'(0), r_oentry, r_ostatus};
    assign o_m_tlast  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above capacity");

    a_disp_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DISP |-> (r_left != '0) && (r_left <= r_count))
        else $error("display counter out of range");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> out_free)
        else $error("item taken while output register full");

    a_delv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DELV) && out_free |=> r_ovalid && o_m_tlast)
        else $error("delete-value gave no final result");

endmodule
`default_nettype wire
